>>> hw/rtl/affirmative_sampling_sketch_macros.svh
// assertion macros used by the checker file
`ifndef AFFIRMATIVE_SAMPLING_SKETCH_MACROS_SVH
`define AFFIRMATIVE_SAMPLING_SKETCH_MACROS_SVH

// same-cycle implication, off during reset
`define AFFS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off during reset
`define AFFS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// next-cycle implication that also covers reset
`define AFFS_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/affs_pkg.sv
package affs_pkg;

  localparam int HASH_W = 64;

  typedef enum logic [2:0] {
    OC_DUP      = 3'd0,
    OC_FILL     = 3'd1,
    OC_REJECT   = 3'd2,
    OC_REPLACE  = 3'd3,
    OC_GROW     = 3'd4,
    OC_OVERFLOW = 3'd5,
    OC_READ     = 3'd6
  } outcome_t;

  typedef struct packed {
    logic capture;
    logic insert;
  } cell_ctl_t;

endpackage

>>> hw/rtl/affs_cell.sv
module affs_cell #(
  parameter int CAPACITY = 256,
  parameter int IDX      = 0
) (
  input  logic                          clk,
  input  affs_pkg::cell_ctl_t           ctl,
  input  logic [affs_pkg::HASH_W-1:0]   hash,
  input  logic [$clog2(CAPACITY+1)-1:0] count,
  input  logic [affs_pkg::HASH_W-1:0]   left_val,
  input  logic                          left_lt,
  output logic [affs_pkg::HASH_W-1:0]   val,
  output logic                          lt,
  output logic                          eq
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic held;
  logic lt_now;

  always_comb begin
    held   = CW'(IDX) < count;
    lt_now = held && (val < hash);
    eq     = held && (val == hash);
  end

  // lt marks entries below the offered hash; the first cell without it takes the hash
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      lt <= lt_now;
    end
    if (ctl.insert && !lt) begin
      val <= left_lt ? hash : left_val;
    end
  end

endmodule

>>> hw/rtl/affirmative_sampling_sketch.sv
// Sorted sketch of distinct 64-bit hashes with upper and lower thresholds.
// Input channel (in_valid/in_ready): action 0 offers hash_value, action 1
// reads the entry at read_index in ascending order. Each beat yields one
// result beat on the output channel (out_valid/out_ready) carrying outcome,
// sketch_size, read_value and read_valid.
// Timing: an accepted beat passes through the compare pass, where every cell
// compares its entry with the hash, and then the update pass, where the cells
// shift to make room. The result is registered at the end of the update pass,
// and the next beat is taken at that same edge, so a new beat is taken only
// once the last one has finished the compare and shift passes through the
// row of cells.
// sample_size (APB, byte address 0) may only be written while no beat is in
// flight. Reset empties the sketch, zeroes both thresholds, sets
// sample_size to 32 and clears out_valid; no clearing pass.
// When out_ready is low the result stays in the output register; one more
// beat may be accepted and compared, then the block holds in its update
// pass with in_ready low until the result is taken.
module affirmative_sampling_sketch #(
  parameter int CAPACITY = 256
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        action,
  input  logic [affs_pkg::HASH_W-1:0] hash_value,
  input  logic [7:0]                  read_index,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [2:0]                  outcome,
  output logic [8:0]                  sketch_size,
  output logic [affs_pkg::HASH_W-1:0] read_value,
  output logic                        read_valid,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int HW = affs_pkg::HASH_W;
  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = IW + 9;

  typedef enum logic [1:0] {ST_IDLE, ST_CMP, ST_UPD} state_t;

  state_t state;

  logic [7:0]    sample_size;
  logic [CW-1:0] count;
  logic [HW-1:0] upper;
  logic [HW-1:0] lower;

  logic          act_r;
  logic [HW-1:0] h_r;
  logic [7:0]    ri_r;
  logic          dup_r;
  logic          fill_r;
  logic          k_two_r;
  logic          full_r;
  logic          rd_ok_r;
  logic [HW-1:0] v_lo;
  logic [HW-1:0] v_km1;
  logic [HW-1:0] v_top;

  logic [HW-1:0]       cell_val [CAPACITY];
  logic [HW-1:0]       left_val [CAPACITY];
  logic [CAPACITY-1:0] cell_lt;
  logic [CAPACITY-1:0] cell_eq;
  logic [CAPACITY-1:0] left_lt;

  affs_pkg::cell_ctl_t  ctl;
  affs_pkg::outcome_t   oc;

  logic          accept;
  logic          finish;
  logic          do_ins;
  logic [CW-1:0] cnt_next;
  logic [HW-1:0] up_next;
  logic [HW-1:0] lo_next;
  logic [HW-1:0] kth;
  logic [EW-1:0] ss_e;
  logic [EW-1:0] cap_e;
  logic [EW-1:0] k_e;
  logic [EW-1:0] n_e;
  logic [EW-1:0] rd_e;
  logic [EW-1:0] sz_e;
  logic [IW-1:0] k_i;
  logic [IW-1:0] km1_i;
  logic [IW-1:0] km2_i;
  logic [IW-1:0] nm2_i;
  logic [IW-1:0] rd_i;
  logic [IW-1:0] a_i;

  // row of cells, each passing its entry and flag to the right
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign left_val[i] = '0;
      assign left_lt[i]  = 1'b1;
    end else begin : g_link
      assign left_val[i] = cell_val[i-1];
      assign left_lt[i]  = cell_lt[i-1];
    end
    affs_cell #(
      .CAPACITY (CAPACITY),
      .IDX      (i)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .hash     (h_r),
      .count    (count),
      .left_val (left_val[i]),
      .left_lt  (left_lt[i]),
      .val      (cell_val[i]),
      .lt       (cell_lt[i]),
      .eq       (cell_eq[i])
    );
  end

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {24'd0, sample_size};

  assign finish   = (state == ST_UPD) && (!out_valid || out_ready);
  assign in_ready = (state == ST_IDLE) || finish;
  assign accept   = in_valid && in_ready;

  always_comb begin
    ctl.capture = state == ST_CMP;
    ctl.insert  = finish && do_ins;
  end

  // effective target and the cell positions read during the compare pass
  always_comb begin
    ss_e  = EW'(sample_size);
    cap_e = EW'(CAPACITY);
    n_e   = EW'(count);
    if (ss_e >= cap_e) begin
      k_e = cap_e - EW'(1);
    end else if (ss_e == '0) begin
      k_e = EW'(1);
    end else begin
      k_e = ss_e;
    end
    k_i   = k_e[IW-1:0];
    km1_i = k_i - IW'(1);
    km2_i = k_i - IW'(2);
    nm2_i = n_e[IW-1:0] - IW'(2);
    rd_e  = EW'(ri_r);
    rd_i  = rd_e[IW-1:0];
    // one shared position: read entry, second largest or the one below k-1
    if (act_r) begin
      a_i = rd_i;
    end else if (h_r > lower) begin
      a_i = nm2_i;
    end else begin
      a_i = km2_i;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_r <= action;
      h_r   <= hash_value;
      ri_r  <= read_index;
    end
    if (state == ST_CMP) begin
      dup_r   <= |cell_eq;
      fill_r  <= n_e < k_e;
      k_two_r <= k_e >= EW'(2);
      full_r  <= n_e == cap_e;
      rd_ok_r <= rd_e < n_e;
      v_lo    <= cell_val[a_i];
      v_km1   <= cell_val[km1_i];
      v_top   <= cell_val[CAPACITY-2];
    end
  end

  // new k-th smallest once the hash is placed
  always_comb begin
    if (k_two_r && !(v_lo < h_r)) begin
      kth = v_lo;
    end else if (!(v_km1 < h_r)) begin
      kth = h_r;
    end else begin
      kth = v_km1;
    end
  end

  always_comb begin
    up_next  = upper;
    lo_next  = lower;
    cnt_next = count;
    do_ins   = 1'b0;
    oc       = affs_pkg::OC_READ;
    if (!act_r) begin
      if (dup_r) begin
        oc = affs_pkg::OC_DUP;
      end else if (fill_r) begin
        oc       = affs_pkg::OC_FILL;
        do_ins   = 1'b1;
        cnt_next = count + CW'(1);
        up_next  = (count == '0 || upper < h_r) ? h_r : upper;
        lo_next  = up_next;
      end else if (h_r > upper) begin
        oc = affs_pkg::OC_REJECT;
      end else if (h_r > lower) begin
        oc      = affs_pkg::OC_REPLACE;
        do_ins  = 1'b1;
        up_next = (count == CW'(1) || v_lo < h_r) ? h_r : v_lo;
      end else begin
        do_ins  = 1'b1;
        lo_next = kth;
        if (full_r) begin
          oc      = affs_pkg::OC_OVERFLOW;
          up_next = (v_top < h_r) ? h_r : v_top;
        end else begin
          oc       = affs_pkg::OC_GROW;
          cnt_next = count + CW'(1);
        end
      end
    end
    sz_e = EW'(cnt_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      out_valid   <= 1'b0;
      count       <= '0;
      upper       <= '0;
      lower       <= '0;
      sample_size <= 8'd32;
    end else begin
      if (psel && penable && pwrite && !paddr[2]) begin
        sample_size <= pwdata[7:0];
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_CMP;
          end
        end
        ST_CMP: begin
          state <= ST_UPD;
        end
        ST_UPD: begin
          if (accept) begin
            state <= ST_CMP;
          end else if (finish) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (finish) begin
        out_valid   <= 1'b1;
        count       <= cnt_next;
        upper       <= up_next;
        lower       <= lo_next;
        outcome     <= oc;
        sketch_size <= sz_e[8:0];
        read_value  <= (act_r && rd_ok_r) ? v_lo : '0;
        read_valid  <= act_r && rd_ok_r;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> hw/rtl/affs_checker.sv
`include "affirmative_sampling_sketch_macros.svh"

module affs_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [2:0]                  outcome,
  input logic [8:0]                  sketch_size,
  input logic [affs_pkg::HASH_W-1:0] read_value,
  input logic                        read_valid
);

  `AFFS_ASSERT_RST(a_rst_empty, rst, !out_valid, "output beat present after reset")

  `AFFS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(outcome) && $stable(sketch_size) && $stable(read_value), "stalled output beat changed")

  `AFFS_ASSERT_NOW(a_offer_no_data, out_valid && outcome != affs_pkg::OC_READ, !read_valid && read_value == '0, "offer beat carries read data")

  `AFFS_ASSERT_NOW(a_grow_nonempty, out_valid && (outcome == affs_pkg::OC_FILL || outcome == affs_pkg::OC_GROW), sketch_size != 9'd0, "insert left sketch empty")

endmodule

bind affirmative_sampling_sketch affs_checker u_affs_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .outcome     (outcome),
  .sketch_size (sketch_size),
  .read_value  (read_value),
  .read_valid  (read_valid)
);

>>> tb/affirmative_sampling_sketch_tb.sv
`timescale 1ns / 100ps

module testbench;

  localparam int CAPACITY = 256;
  localparam int CYCLE_LIMIT = 500000;
  localparam int PHASES = 9;
  localparam logic ACT_OFFER = 1'b0;
  localparam logic ACT_READ = 1'b1;
  localparam logic [2:0] SAMPLE_SIZE_ADDR = 3'd0;

  typedef struct packed {
    logic        act;
    logic [63:0] hash;
    logic [7:0]  idx;
  } sketch_beat_t;

  typedef struct packed {
    affs_pkg::outcome_t oc;
    logic [8:0]         size;
    logic [63:0]        value;
    logic               valid;
  } sketch_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        action = 1'b0;
  logic [63:0] hash_value = '0;
  logic [7:0]  read_index = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  outcome;
  logic [8:0]  sketch_size;
  logic [63:0] read_value;
  logic        read_valid;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // shadow of the sketch
  logic [63:0] held_hash [CAPACITY];
  int          held_n = 0;
  logic [63:0] upper_thr = '0;
  logic [63:0] lower_thr = '0;
  logic [7:0]  sample_k = 8'd32;

  sketch_beat_t   beat_queue [$];
  sketch_result_t due_results [$];

  int errors = 0;
  int cycle_count = 0;
  int stall_mode = 0;
  bit sender_gappy = 1'b0;
  int burst_left = 1;
  int gap_left = 0;
  int hold_left = 0;
  int taken = 0;
  bit long_hold_done = 1'b0;

  logic [7:0] phase_k [PHASES] = '{8'd0, 8'd1, 8'd5, 8'd32, 8'd100, 8'd255, 8'd254, 8'd8,
                                   8'd255};
  int phase_items [PHASES] = '{150, 150, 150, 200, 200, 500, 150, 150, 100};

  affirmative_sampling_sketch #(.CAPACITY(CAPACITY)) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .hash_value(hash_value), .read_index(read_index),
    .out_valid(out_valid), .out_ready(out_ready),
    .outcome(outcome), .sketch_size(sketch_size),
    .read_value(read_value), .read_valid(read_valid),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic int target_count();
    int k;
    k = sample_k;
    if (k >= CAPACITY) k = CAPACITY - 1;
    if (k == 0) k = 1;
    return k;
  endfunction

  // ordered insert; a full store drops its largest entry
  function automatic bit sorted_insert(logic [63:0] h);
    int n;
    int p;
    n = held_n;
    p = 0;
    while (p < n && held_hash[p] < h) p++;
    if (n < CAPACITY) begin
      for (int i = n; i > p; i--) held_hash[i] = held_hash[i-1];
      held_hash[p] = h;
      held_n = n + 1;
      return 1'b1;
    end
    if (p < CAPACITY) begin
      for (int i = CAPACITY - 1; i > p; i--) held_hash[i] = held_hash[i-1];
      held_hash[p] = h;
    end
    return 1'b0;
  endfunction

  function automatic affs_pkg::outcome_t offer_hash(logic [63:0] h);
    int k;
    k = target_count();
    for (int i = 0; i < held_n; i++) begin
      if (held_hash[i] == h) return affs_pkg::OC_DUP;
    end
    if (held_n < k) begin
      void'(sorted_insert(h));
      upper_thr = held_hash[held_n-1];
      lower_thr = upper_thr;
      return affs_pkg::OC_FILL;
    end
    if (h > upper_thr) return affs_pkg::OC_REJECT;
    if (h > lower_thr) begin
      if (sorted_insert(h)) held_n--;
      upper_thr = held_hash[held_n-1];
      return affs_pkg::OC_REPLACE;
    end
    if (sorted_insert(h)) begin
      lower_thr = held_hash[k-1];
      return affs_pkg::OC_GROW;
    end
    lower_thr = held_hash[k-1];
    upper_thr = held_hash[held_n-1];
    return affs_pkg::OC_OVERFLOW;
  endfunction

  function automatic void sketch_step(sketch_beat_t b);
    sketch_result_t r;
    r.value = '0;
    r.valid = 1'b0;
    if (b.act == ACT_OFFER) begin
      r.oc = offer_hash(b.hash);
    end else begin
      r.oc = affs_pkg::OC_READ;
      if (b.idx < held_n) begin
        r.value = held_hash[b.idx];
        r.valid = 1'b1;
      end
    end
    r.size = 9'(held_n);
    due_results.push_back(r);
  endfunction

  // beats, mostly offers, with hashes aimed around the thresholds and at held entries
  function automatic sketch_beat_t make_beat();
    sketch_beat_t b;
    logic [63:0] span;
    b.act = ($urandom_range(0, 4) == 0) ? ACT_READ : ACT_OFFER;
    b.idx = (held_n != 0 && $urandom_range(0, 1) == 1) ? 8'($urandom_range(0, held_n - 1))
                                                         : 8'($urandom);
    span = upper_thr - lower_thr;
    case ($urandom_range(0, 9))
      0: b.hash = 64'($urandom_range(0, 63));
      1: b.hash = (held_n != 0) ? held_hash[$urandom_range(0, held_n - 1)] : '1;
      2: b.hash = upper_thr + $urandom_range(0, 2) - 1;
      3: b.hash = lower_thr + $urandom_range(0, 2) - 1;
      4: b.hash = (span > 1) ? lower_thr + 1 + ({$urandom, $urandom} % span)
                             : {$urandom, $urandom};
      5: b.hash = (lower_thr != 0) ? {$urandom, $urandom} % lower_thr : '0;
      6: b.hash = ($urandom_range(0, 1) == 1) ? '1 : '0;
      default: b.hash = {$urandom, $urandom};
    endcase
    return b;
  endfunction

  task automatic queue_beat(input logic act, input logic [63:0] h, input logic [7:0] idx);
    sketch_beat_t b;
    b.act = act;
    b.hash = h;
    b.idx = idx;
    beat_queue.push_back(b);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (beat_queue.size() != 0 || in_valid || due_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_sample_size(input logic [7:0] k);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= SAMPLE_SIZE_ADDR;
    pwdata <= {24'($urandom), k};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sample_k = k;
  endtask

  // driver
  always @(posedge clk) begin : driver
    sketch_beat_t nb;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) sketch_step({action, hash_value, read_index});
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (beat_queue.size() != 0) begin
          nb = beat_queue.pop_front();
          in_valid <= 1'b1;
          action <= nb.act;
          hash_value <= nb.hash;
          read_index <= nb.idx;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 16);
            gap_left = sender_gappy ? $urandom_range(1, 8) : 0;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) taken++;
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!long_hold_done && taken >= 300) begin
        long_hold_done = 1'b1;
        hold_left = 120;
        out_ready <= 1'b0;
      end else if ($urandom_range(0, 999) == 0) begin
        hold_left = $urandom_range(30, 80);
        out_ready <= 1'b0;
      end else begin
        case (stall_mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 1) == 1);
          2: out_ready <= ($urandom_range(0, 3) != 0);
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // monitor
  always @(posedge clk) begin : monitor
    sketch_result_t r;
    if (!rst && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result beat, outcome %0d", $time, outcome);
        errors++;
      end else begin
        r = due_results.pop_front();
        if (outcome !== r.oc) begin
          $display("%0t: outcome expected %0d actual %0d", $time, r.oc, outcome);
          errors++;
        end
        if (sketch_size !== r.size) begin
          $display("%0t: sketch_size expected %0d actual %0d", $time, r.size, sketch_size);
          errors++;
        end
        if (read_value !== r.value) begin
          $display("%0t: read_value expected %h actual %h", $time, r.value, read_value);
          errors++;
        end
        if (read_valid !== r.valid) begin
          $display("%0t: read_valid expected %0d actual %0d", $time, r.valid, read_valid);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("affirmative_sampling_sketch test failed");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // small k so every outcome but overflow shows up in a few beats
    write_sample_size(8'd2);
    queue_beat(ACT_READ, {$urandom, $urandom}, 8'd0);
    queue_beat(ACT_READ, {$urandom, $urandom}, 8'd255);
    queue_beat(ACT_OFFER, 64'd100, 8'($urandom));
    queue_beat(ACT_OFFER, 64'd100, 8'($urandom));
    queue_beat(ACT_OFFER, 64'd0, 8'($urandom));
    queue_beat(ACT_OFFER, 64'd200, 8'($urandom));
    queue_beat(ACT_OFFER, 64'd50, 8'($urandom));
    queue_beat(ACT_OFFER, 64'd75, 8'($urandom));
    queue_beat(ACT_OFFER, '1, 8'($urandom));
    queue_beat(ACT_OFFER, 64'd50, 8'($urandom));
    queue_beat(ACT_READ, '1, 8'd0);
    queue_beat(ACT_READ, {$urandom, $urandom}, 8'd2);
    queue_beat(ACT_READ, {$urandom, $urandom}, 8'd3);
    queue_beat(ACT_READ, '0, 8'd255);
    queue_beat(ACT_OFFER, 64'd10, 8'($urandom));
    queue_beat(ACT_OFFER, 64'd0, 8'($urandom));
    queue_beat(ACT_OFFER, 64'd1, 8'($urandom));
    queue_beat(ACT_READ, {$urandom, $urandom}, 8'd1);
    wait_idle();

    for (int ph = 0; ph < PHASES; ph++) begin
      stall_mode = ph % 4;
      sender_gappy = (ph % 3 != 1);
      write_sample_size(phase_k[ph]);
      for (int n = 0; n < phase_items[ph]; n++) begin
        while (beat_queue.size() >= 4) @(posedge clk);
        beat_queue.push_back(make_beat());
      end
      wait_idle();
    end

    repeat (10) @(posedge clk);
    if (errors == 0 && due_results.size() == 0) begin
      $display("affirmative_sampling_sketch test passed");
    end else begin
      $display("affirmative_sampling_sketch test failed");
    end
    $finish;
  end

endmodule
